// ===== rtl/tlex_pkg.sv =====
// shared types, token codes and keyword tables for the small c lexer
`timescale 1ns / 1ps

package tlex_pkg;

    localparam int TLEX_MAX_TEXT = 32;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_NUM  = 2'd1;
    localparam logic [1:0] MODE_ID   = 2'd2;
    localparam logic [1:0] MODE_STR  = 2'd3;

    localparam logic [4:0] K_LBRA  = 5'd6;
    localparam logic [4:0] K_RBRA  = 5'd7;
    localparam logic [4:0] K_LPAR  = 5'd8;
    localparam logic [4:0] K_RPAR  = 5'd9;
    localparam logic [4:0] K_PLUS  = 5'd10;
    localparam logic [4:0] K_DIV   = 5'd11;
    localparam logic [4:0] K_MUL   = 5'd12;
    localparam logic [4:0] K_MINUS = 5'd13;
    localparam logic [4:0] K_LESS  = 5'd14;
    localparam logic [4:0] K_SEMI  = 5'd15;
    localparam logic [4:0] K_EQUAL = 5'd16;
    localparam logic [4:0] K_NUM   = 5'd17;
    localparam logic [4:0] K_STR   = 5'd18;
    localparam logic [4:0] K_ID    = 5'd19;
    localparam logic [4:0] K_END   = 5'd20;
    localparam logic [4:0] K_ERR   = 5'd21;

    localparam logic [1:0] SRC_PLAIN = 2'd0;
    localparam logic [1:0] SRC_NUM   = 2'd1;
    localparam logic [1:0] SRC_TEXT  = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] CH_Z     = 8'h7a;

    localparam int KW_COUNT = 6;

    // keyword spellings, padded with zeros to eight positions
    localparam logic [7:0] KW_TEXT [KW_COUNT][8] = '{
        '{8'h64, 8'h6f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h77, 8'h68, 8'h69, 8'h6c, 8'h65, 8'h00, 8'h00, 8'h00},
        '{8'h70, 8'h72, 8'h69, 8'h6e, 8'h74, 8'h00, 8'h00, 8'h00},
        '{8'h73, 8'h79, 8'h73, 8'h74, 8'h65, 8'h6d, 8'h00, 8'h00}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd2, 3'd4, 3'd2, 3'd5, 3'd5, 3'd6};

    typedef struct packed {
        logic       latch_in;
        logic       acc_load;
        logic       acc_mac;
        logic       text_clear;
        logic       text_append;
        logic       run_start;
        logic       run_next;
        logic       out_load;
        logic [1:0] out_src;
        logic [4:0] out_kind;
    } tlex_cmd_t;

    typedef struct packed {
        logic       eoi;
        logic       is_digit;
        logic       is_lower;
        logic       is_ident;
        logic       is_quote;
        logic       is_ws;
        logic [4:0] char_kind;
        logic       kw_hit;
        logic [4:0] kw_code;
        logic       run_last;
        logic       out_free;
    } tlex_sts_t;

    function automatic logic [4:0] tlex_punct(input logic [7:0] c);
        logic [4:0] k;
        case (c)
            8'h7b:   k = K_LBRA;
            8'h7d:   k = K_RBRA;
            8'h28:   k = K_LPAR;
            8'h29:   k = K_RPAR;
            8'h2b:   k = K_PLUS;
            8'h2f:   k = K_DIV;
            8'h2a:   k = K_MUL;
            8'h2d:   k = K_MINUS;
            8'h3c:   k = K_LESS;
            8'h3b:   k = K_SEMI;
            8'h3d:   k = K_EQUAL;
            default: k = K_ERR;
        endcase
        return k;
    endfunction

endpackage

// ===== rtl/tlex_ram.sv =====
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module tlex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data <= mem_reg[rd_addr];
    end

endmodule

// ===== rtl/tlex_ctrl.sv =====
// lexer controller: scan mode and token sequencing state machine
`timescale 1ns / 1ps

module tlex_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output tlex_pkg::tlex_cmd_t  cmd,
    input  tlex_pkg::tlex_sts_t  sts
);
    import tlex_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_EXEC     = 3'd1;
    localparam logic [2:0] ST_RUN_RD   = 3'd2;
    localparam logic [2:0] ST_RUN_EMIT = 3'd3;
    localparam logic [2:0] ST_END      = 3'd4;

    localparam logic [1:0] RET_IDLE = 2'd0;
    localparam logic [1:0] RET_EXEC = 2'd1;
    localparam logic [1:0] RET_END  = 2'd2;

    logic [2:0] state_reg, state_next;
    logic [1:0] mode_reg, mode_next;
    logic [1:0] ret_reg, ret_next;
    logic [4:0] run_kind_reg, run_kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            mode_reg     <= MODE_IDLE;
            ret_reg      <= RET_IDLE;
            run_kind_reg <= K_ID;
        end else begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            ret_reg      <= ret_next;
            run_kind_reg <= run_kind_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        cmd           = '0;
        cmd.out_src   = SRC_PLAIN;
        cmd.out_kind  = K_END;
        state_next    = state_reg;
        mode_next     = mode_reg;
        ret_next      = ret_reg;
        run_kind_next = run_kind_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (sts.eoi) begin
                    case (mode_reg)
                        MODE_NUM: begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_src  = SRC_NUM;
                                cmd.out_kind = K_NUM;
                                mode_next    = MODE_IDLE;
                                state_next   = ST_END;
                            end
                        end
                        MODE_ID: begin
                            if (sts.kw_hit) begin
                                if (sts.out_free) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_kind = sts.kw_code;
                                    mode_next    = MODE_IDLE;
                                    state_next   = ST_END;
                                end
                            end else begin
                                cmd.run_start = 1'b1;
                                run_kind_next = K_ID;
                                ret_next      = RET_END;
                                mode_next     = MODE_IDLE;
                                state_next    = ST_RUN_RD;
                            end
                        end
                        MODE_STR: begin
                            if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = K_ERR;
                                mode_next    = MODE_IDLE;
                                state_next   = ST_END;
                            end
                        end
                        default: begin
                            state_next = ST_END;
                        end
                    endcase
                end else begin
                    case (mode_reg)
                        MODE_NUM: begin
                            if (sts.is_digit) begin
                                cmd.acc_mac = 1'b1;
                                state_next  = ST_IDLE;
                            end else if (sts.out_free) begin
                                // flush number, then lex this byte again
                                cmd.out_load = 1'b1;
                                cmd.out_src  = SRC_NUM;
                                cmd.out_kind = K_NUM;
                                mode_next    = MODE_IDLE;
                            end
                        end
                        MODE_ID: begin
                            if (sts.is_ident) begin
                                cmd.text_append = 1'b1;
                                state_next      = ST_IDLE;
                            end else if (sts.kw_hit) begin
                                if (sts.out_free) begin
                                    cmd.out_load = 1'b1;
                                    cmd.out_kind = sts.kw_code;
                                    mode_next    = MODE_IDLE;
                                end
                            end else begin
                                cmd.run_start = 1'b1;
                                run_kind_next = K_ID;
                                ret_next      = RET_EXEC;
                                mode_next     = MODE_IDLE;
                                state_next    = ST_RUN_RD;
                            end
                        end
                        MODE_STR: begin
                            if (sts.is_quote) begin
                                cmd.run_start = 1'b1;
                                run_kind_next = K_STR;
                                ret_next      = RET_IDLE;
                                mode_next     = MODE_IDLE;
                                state_next    = ST_RUN_RD;
                            end else begin
                                cmd.text_append = 1'b1;
                                state_next      = ST_IDLE;
                            end
                        end
                        default: begin
                            if (sts.is_ws) begin
                                state_next = ST_IDLE;
                            end else if (sts.is_quote) begin
                                cmd.text_clear = 1'b1;
                                mode_next      = MODE_STR;
                                state_next     = ST_IDLE;
                            end else if (sts.is_digit) begin
                                cmd.acc_load = 1'b1;
                                mode_next    = MODE_NUM;
                                state_next   = ST_IDLE;
                            end else if (sts.is_lower) begin
                                cmd.text_clear  = 1'b1;
                                cmd.text_append = 1'b1;
                                mode_next       = MODE_ID;
                                state_next      = ST_IDLE;
                            end else if (sts.out_free) begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = sts.char_kind;
                                state_next   = ST_IDLE;
                            end
                        end
                    endcase
                end
            end
            ST_RUN_RD: begin
                state_next = ST_RUN_EMIT;
            end
            ST_RUN_EMIT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_src  = SRC_TEXT;
                    cmd.out_kind = run_kind_reg;
                    if (sts.run_last) begin
                        case (ret_reg)
                            RET_EXEC: state_next = ST_EXEC;
                            RET_END:  state_next = ST_END;
                            default:  state_next = ST_IDLE;
                        endcase
                    end else begin
                        cmd.run_next = 1'b1;
                        state_next   = ST_RUN_RD;
                    end
                end
            end
            ST_END: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = K_END;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_load_needs_room: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("result word loaded into a full output register");

    a_run_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN_EMIT) |-> (run_kind_reg == K_ID || run_kind_reg == K_STR))
        else $error("text run with a kind other than identifier or string");

    a_end_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_END && cmd.out_load) |=>
            (state_reg == ST_IDLE && mode_reg == MODE_IDLE))
        else $error("end token not followed by idle scan mode");

    a_mode_at_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN_RD || state_reg == ST_RUN_EMIT) |-> (mode_reg == MODE_IDLE))
        else $error("text run while a token is still being scanned");

endmodule

// ===== rtl/tlex_dp.sv =====
// lexer datapath: input word, number accumulator, text buffer, keyword match, output register
`timescale 1ns / 1ps

module tlex_dp #(
    parameter int MAX_TEXT = tlex_pkg::TLEX_MAX_TEXT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [7:0]           s_tdata,
    input  logic                 s_tuser,
    input  tlex_pkg::tlex_cmd_t  cmd,
    output tlex_pkg::tlex_sts_t  sts,
    input  logic                 m_tready,
    output logic                 m_tvalid,
    output logic [47:0]          m_tdata,
    output logic [4:0]           m_tuser,
    output logic                 m_tlast
);
    import tlex_pkg::*;

    localparam int AW = $clog2(MAX_TEXT);
    localparam int LW = $clog2(MAX_TEXT + 1);

    logic [7:0]          char_reg;
    logic                eoi_reg;
    logic [31:0]         acc_reg, acc_next;
    logic [LW-1:0]       len_reg, len_next;
    logic                ovf_reg, ovf_next;
    logic [KW_COUNT-1:0] kw_mask_reg, kw_mask_next;
    logic [AW-1:0]       idx_reg, idx_next;

    logic                out_valid_reg;
    logic [4:0]          out_kind_reg;
    logic [31:0]         out_num_reg;
    logic [7:0]          out_char_reg;
    logic [4:0]          out_index_reg;
    logic                out_trunc_reg;
    logic                out_last_reg;

    logic [7:0]          dsub;
    logic [3:0]          dval;
    logic [LW-1:0]       base_len;
    logic                base_ovf;
    logic [KW_COUNT-1:0] base_mask;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [7:0]          ram_rdata;
    logic                run_last;
    logic                out_free;
    logic                kw_hit;
    logic [4:0]          kw_code;

    // character classes of the held input byte
    always_comb begin
        sts           = '0;
        sts.eoi       = eoi_reg;
        sts.is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
        sts.is_lower  = (char_reg >= CH_A) && (char_reg <= CH_Z);
        sts.is_ident  = sts.is_digit || sts.is_lower || (char_reg == CH_UNDER);
        sts.is_quote  = (char_reg == CH_QUOTE);
        sts.is_ws     = (char_reg == CH_NUL) || (char_reg == CH_SPACE) ||
                        (char_reg == CH_TAB) || (char_reg == CH_LF);
        sts.char_kind = tlex_punct(char_reg);
        sts.kw_hit    = kw_hit;
        sts.kw_code   = kw_code;
        sts.run_last  = run_last;
        sts.out_free  = out_free;
    end

    assign dsub = char_reg - CH_ZERO;
    assign dval = dsub[3:0];

    always_comb begin
        acc_next = acc_reg;
        if (cmd.acc_load) begin
            acc_next = {28'd0, dval};
        end else if (cmd.acc_mac) begin
            acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + {28'd0, dval};
        end
    end

    // text append with running keyword prefix match
    always_comb begin
        base_len     = cmd.text_clear ? '0 : len_reg;
        base_ovf     = cmd.text_clear ? 1'b0 : ovf_reg;
        base_mask    = cmd.text_clear ? '1 : kw_mask_reg;
        len_next     = base_len;
        ovf_next     = base_ovf;
        kw_mask_next = base_mask;
        ram_we       = 1'b0;
        ram_waddr    = base_len[AW-1:0];
        if (cmd.text_append) begin
            if (base_len < LW'(MAX_TEXT)) begin
                ram_we   = 1'b1;
                len_next = base_len + LW'(1);
                for (int w = 0; w < KW_COUNT; w++) begin
                    kw_mask_next[w] = base_mask[w] && (base_len < LW'(KW_LEN[w])) &&
                                      (char_reg == KW_TEXT[w][base_len[2:0]]);
                end
            end else begin
                ovf_next = 1'b1;
            end
        end
    end

    always_comb begin
        kw_hit  = 1'b0;
        kw_code = K_ID;
        for (int w = KW_COUNT - 1; w >= 0; w--) begin
            if (kw_mask_reg[w] && (len_reg == LW'(KW_LEN[w]))) begin
                kw_hit  = !ovf_reg;
                kw_code = 5'(w);
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.run_start) begin
            idx_next = '0;
        end else if (cmd.run_next) begin
            idx_next = idx_reg + AW'(1);
        end
    end

    assign run_last = (len_reg == '0) || ((LW'(idx_reg) + LW'(1)) == len_reg);
    assign out_free = !out_valid_reg || m_tready;

    tlex_ram #(
        .WIDTH (8),
        .DEPTH (MAX_TEXT)
    ) u_text_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (char_reg),
        .rd_addr (idx_reg),
        .rd_data (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eoi_reg     <= 1'b0;
            acc_reg     <= '0;
            len_reg     <= '0;
            ovf_reg     <= 1'b0;
            kw_mask_reg <= '0;
            idx_reg     <= '0;
        end else begin
            if (cmd.latch_in) begin
                eoi_reg <= s_tuser;
            end
            acc_reg     <= acc_next;
            len_reg     <= len_next;
            ovf_reg     <= ovf_next;
            kw_mask_reg <= kw_mask_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            char_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_kind_reg  <= cmd.out_kind;
            out_num_reg   <= (cmd.out_src == SRC_NUM) ? acc_reg : 32'd0;
            out_char_reg  <= (cmd.out_src == SRC_TEXT && len_reg != '0) ? ram_rdata : 8'd0;
            out_index_reg <= (cmd.out_src == SRC_TEXT) ? 5'(idx_reg) : 5'd0;
            out_trunc_reg <= (cmd.out_src == SRC_TEXT) ? ovf_reg : 1'b0;
            out_last_reg  <= (cmd.out_src == SRC_TEXT) ? run_last : 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_trunc_reg, out_index_reg, out_char_reg, out_num_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LW'(MAX_TEXT))
        else $error("text length past buffer size");

    a_kw_not_truncated: assert property (@(posedge aclk) disable iff (!aresetn)
        kw_hit |-> (!ovf_reg && len_reg <= LW'(6)))
        else $error("keyword hit on overlong text");

    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result word not presented");

endmodule

// ===== rtl/token_lexer_small_c.sv =====
// token_lexer_small_c: a source byte in, a result word out per token or text character
// idle takes a byte and exec decodes it, and no new byte is taken meanwhile; a loaded result is
// valid next cycle; a token ended by the next byte is flushed, then that byte is decoded again;
// the end token has its own state; each text char is read from the registered ram, then emitted
// synchronous active-low reset clears scan mode, counters and the output valid;
// the text buffer ram is not cleared and needs no clearing pass
`timescale 1ns / 1ps

module token_lexer_small_c #(
    parameter int MAX_TEXT = tlex_pkg::TLEX_MAX_TEXT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_in
    input  logic        s_tuser,   // end_of_input
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // number_value, text_char, text_index, truncated, 2 zero bits
    output logic [4:0]  m_tuser,   // token_kind
    output logic        m_tlast
);
    import tlex_pkg::*;

    tlex_cmd_t cmd;
    tlex_sts_t sts;

    tlex_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    tlex_dp #(
        .MAX_TEXT (MAX_TEXT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cmd      (cmd),
        .sts      (sts),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
